// ===== rtl/bffa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_pkg
// shared types, codes and default sizes of the bitmap first-free allocator
// ----------------------------------------------------------------------------
package bffa_pkg;

  localparam int DEF_ENTRIES   = 4096;
  localparam int DEF_WORD_BITS = 8;

  localparam int ID_W   = 12;
  localparam int CNT_W  = 13;
  localparam int STAT_W = 2;

  localparam logic [CNT_W-1:0] CNT_RESET = 13'd4096;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK            = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL          = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_ALLOCATED = 2'd2;
  localparam logic [STAT_W-1:0] ST_OUT_OF_RANGE  = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_SEEK,
    S_FREE_CHK,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   id;
  } result_t;

endpackage

// ===== rtl/bffa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module bffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bffa_pick.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_pick
// finds the lowest free bit of one map word that lies below the entry count
// ----------------------------------------------------------------------------
module bffa_pick #(
  parameter int WORD_BITS = 8,
  parameter int BW = 13,
  parameter int ECW = 13,
  localparam int BPW = $clog2(WORD_BITS)
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic [BW-1:0]        base,
  input  logic [ECW-1:0]       count,
  output logic                 found,
  output logic [BPW-1:0]       idx
);

  localparam int CMPW = (BW > ECW ? BW : ECW) + 1;

  logic [WORD_BITS-1:0] avail;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      avail[b] = !word[b] && ((CMPW'(base) + CMPW'(b)) < CMPW'(count));
    end
  end

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (avail[b] && !found) begin
        found = 1'b1;
        idx   = BPW'(b);
      end
    end
  end

endmodule

// ===== rtl/bffa_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_engine
// sequencer around the map ram: clearing pass, word scan, free lookup
// ----------------------------------------------------------------------------
module bffa_engine
  import bffa_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES,
  parameter int WORD_BITS = DEF_WORD_BITS,
  localparam int ECW = $clog2(ENTRIES + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic            opcode,
  input  logic            pool,
  input  logic [ID_W-1:0] free_id,
  input  logic [ECW-1:0]  count,
  output logic            busy,
  output result_t         res,
  input  logic            res_take
);

  localparam int WORDS = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int DEPTH = 2 * WORDS;
  localparam int AW    = $clog2(DEPTH);
  localparam int WCW   = $clog2(WORDS + 1);
  localparam int BW    = $clog2(ENTRIES + WORD_BITS + 1);
  localparam int BPW   = $clog2(WORD_BITS);
  localparam int CMPW  = (BW > ID_W ? BW : ID_W) + 1;

  state_t state, state_next;

  logic                 pool_q;
  logic [ID_W-1:0]      fid_q;
  logic [WCW-1:0]       rd_w;
  logic [BW-1:0]        rd_base;
  logic [WCW-1:0]       chk_w;
  logic [BW-1:0]        chk_base;
  logic                 chk_valid;
  logic                 primed;
  logic [AW-1:0]        clr_addr;
  logic [STAT_W-1:0]    res_status;
  logic [ID_W-1:0]      res_id;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        chk_addr;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] rd_data;
  logic                 res_load;
  logic [STAT_W-1:0]    status_next;
  logic [ID_W-1:0]      id_next;

  logic                 pick_found;
  logic [BPW-1:0]       pick_idx;
  logic [BPW-1:0]       free_bit;
  logic [BW-1:0]        grant_sum;
  logic                 in_oor;
  logic                 rd_in_range;
  logic                 seek_hit;
  logic                 scan_hit;
  logic                 scan_full;

  assign rd_addr  = pool_q ? AW'(WORDS) + AW'(rd_w) : AW'(rd_w);
  assign chk_addr = pool_q ? AW'(WORDS) + AW'(chk_w) : AW'(chk_w);

  assign in_oor      = CMPW'(free_id) >= CMPW'(count);
  assign rd_in_range = CMPW'(rd_base) < CMPW'(count);
  assign seek_hit    = CMPW'(fid_q) < (CMPW'(rd_base) + CMPW'(WORD_BITS));
  assign scan_hit    = chk_valid && pick_found;
  assign scan_full   = primed && !chk_valid;
  assign free_bit    = BPW'(CMPW'(fid_q) - CMPW'(chk_base));
  assign grant_sum   = chk_base + BW'(pick_idx);

  bffa_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  bffa_pick #(
    .WORD_BITS(WORD_BITS),
    .BW       (BW),
    .ECW      (ECW)
  ) u_pick (
    .word (rd_data),
    .base (chk_base),
    .count(count),
    .found(pick_found),
    .idx  (pick_idx)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (opcode == OP_ALLOC) begin
            state_next = S_SCAN;
          end else if (in_oor) begin
            state_next = S_HOLD;
          end else begin
            state_next = S_SEEK;
          end
        end
      end
      S_SCAN: begin
        if (scan_hit || scan_full) begin
          state_next = S_HOLD;
        end
      end
      S_SEEK: begin
        if (seek_hit) begin
          state_next = S_FREE_CHK;
        end
      end
      S_FREE_CHK: state_next = S_HOLD;
      S_HOLD: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // memory access and result
  always_comb begin
    rd_en       = 1'b0;
    we          = 1'b0;
    waddr       = chk_addr;
    wdata       = '0;
    res_load    = 1'b0;
    status_next = ST_OK;
    id_next     = '0;
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
      end
      S_IDLE: begin
        if (in_fire && opcode == OP_FREE && in_oor) begin
          res_load    = 1'b1;
          status_next = ST_OUT_OF_RANGE;
        end
      end
      S_SCAN: begin
        rd_en = rd_in_range;
        if (scan_hit) begin
          we       = 1'b1;
          wdata    = rd_data | (WORD_BITS'(1) << pick_idx);
          res_load = 1'b1;
          id_next  = ID_W'(grant_sum);
        end else if (scan_full) begin
          res_load    = 1'b1;
          status_next = ST_FULL;
        end
      end
      S_SEEK: begin
        rd_en = seek_hit;
      end
      S_FREE_CHK: begin
        res_load = 1'b1;
        if (rd_data[free_bit]) begin
          we    = 1'b1;
          wdata = rd_data & ~(WORD_BITS'(1) << free_bit);
        end else begin
          status_next = ST_NOT_ALLOCATED;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      chk_valid <= 1'b0;
      primed    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == S_SCAN) begin
        chk_valid <= rd_en;
        primed    <= 1'b1;
      end else begin
        chk_valid <= 1'b0;
        primed    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_fire) begin
      pool_q  <= pool;
      fid_q   <= free_id;
      rd_w    <= '0;
      rd_base <= '0;
    end
    if ((state == S_SCAN && rd_en) || (state == S_SEEK && !seek_hit)) begin
      rd_w    <= rd_w + WCW'(1);
      rd_base <= rd_base + BW'(WORD_BITS);
    end
    // word under check is registered alongside the read, so it lines up with the ram output
    if (state == S_SCAN || (state == S_SEEK && seek_hit)) begin
      chk_w    <= rd_w;
      chk_base <= rd_base;
    end
    if (res_load) begin
      res_status <= status_next;
      res_id     <= id_next;
    end
  end

  assign busy       = (state != S_IDLE);
  assign res.valid  = (state == S_HOLD);
  assign res.status = res_status;
  assign res.id     = res_id;

endmodule

// ===== rtl/bitmap_first_free_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator
// two-pool used/free bitmap allocator granting the lowest free id
// ----------------------------------------------------------------------------
// Requests come in on in_valid/in_stall with opcode, pool and free_id; one
// result per request leaves on out_valid/out_stall with status and granted_id.
// entry_count is written over cfg_valid/cfg_ready (always ready); the user
// must write it only while no request is in flight; the block does not enforce it.
// Both maps live in one ram of 2*ceil(ENTRIES/WORD_BITS) words, read one word
// per cycle. An allocate reads words upward until the first one with a free id
// below the count (at most ceil(count/WORD_BITS) words, 512 at default size).
// A free walks to its word and checks its bit; an out-of-range free is
// answered without a map read.
// After reset a clearing pass writes every map word to zero, one per cycle
// (1024 words at default size); in_stall stays high until it ends.
// entry_count resets to 4096.
// A finished result sits in the output register while the next request is
// taken and processed; that request's result waits inside until out_stall
// drops and the register empties.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator
  import bffa_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              opcode,
  input  logic              pool,
  input  logic [ID_W-1:0]   free_id,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] status,
  output logic [ID_W-1:0]   granted_id,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data
);

  localparam int ECW = $clog2(ENTRIES + 1);
  localparam int MW  = CNT_W > ECW ? CNT_W : ECW;

  logic [CNT_W-1:0] entry_count;
  logic [MW-1:0]    cnt_ext;
  logic [ECW-1:0]   count;
  logic             busy;
  logic             res_take;
  result_t          res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= CNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  // counts above capacity act as the capacity
  assign cnt_ext = MW'(entry_count);
  assign count   = (cnt_ext > MW'(ENTRIES)) ? ECW'(ENTRIES) : ECW'(cnt_ext);

  bffa_engine #(
    .ENTRIES  (ENTRIES),
    .WORD_BITS(WORD_BITS)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_valid && !in_stall),
    .opcode  (opcode),
    .pool    (pool),
    .free_id (free_id),
    .count   (count),
    .busy    (busy),
    .res     (res),
    .res_take(res_take)
  );

  assign in_stall = busy;
  assign res_take = res.valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      status     <= res.status;
      granted_id <= res.id;
    end
  end

endmodule
